### design/cdq_pkg.sv
// Shared types and constants of the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;
    localparam int CAP_W  = 5;
    localparam int ST_W   = 2;

    // Output tdata: result_data, is_empty, is_full, occupancy, rounded to bytes
    localparam int OUT_BITS   = DATA_W + 2 + CAP_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_REAR  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_OVER  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

### design/cdq_mem.sv
// Entry store of the deque: one write port, one read port with registered data.
`timescale 1ns / 1ps

module cdq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                       i_clk,
    input  cdq_pkg::t_mem_ctl          i_ctl,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [cdq_pkg::DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [cdq_pkg::DATA_W-1:0] o_rd_data
);

    logic [cdq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [cdq_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/circular_deque_core.sv
// Circular deque top level: request handling, ring indices and result register.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request code
//   (push front/rear, pop front/rear, peek front/rear), tdata the word to push.
//   One result per request leaves on m_axis: tuser carries the status
//   (ok, overflow, underflow), tdata the read word, empty and full flags and
//   the occupancy after the request.
//   Pushes, unused codes and underflowing reads: the result is valid the
//   cycle after the transaction. Pops and peeks of a non-empty deque wait
//   in S_READ for the registered read data of the entry store; the
//   next request is taken once the read data sits in the result register.
//   The result register holds until the receiver takes it; while it holds,
//   s_axis tready stays low. A request arriving as the result is taken
//   is accepted in that same cycle.
//   The cfg channel writes the capacity (1..DEPTH, wider values clamp);
//   a write also empties the deque. It is taken only between requests.
//   After reset the deque is empty, capacity is 16, no result is pending.
//   Stored words are not cleared by reset and need no clearing pass.
`timescale 1ns / 1ps

module circular_deque_core #(
    parameter int DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // cfg data: capacity
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]      i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: value[31:0]
    input  logic [cdq_pkg::DATA_W-1:0]     i_s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [cdq_pkg::REQ_W-1:0]      i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: result_data[31:0], is_empty[32], is_full[33], occupancy[38:34], zero pad
    output logic [cdq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: status[1:0]
    output logic [cdq_pkg::ST_W-1:0]       o_m_axis_tuser
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (AW > cdq_pkg::CAP_W) ? AW : cdq_pkg::CAP_W;
    localparam int DW = cdq_pkg::DATA_W;
    localparam int CW = cdq_pkg::CAP_W;
    localparam int PADW = cdq_pkg::OUT_DATA_W - cdq_pkg::OUT_BITS;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] idx,
                                               input logic [XW-1:0] cap);
        logic [XW-1:0] ix;
        ix = XW'(idx);
        if (ix == '0 || ix >= cap) begin
            return AW'(cap - XW'(1));
        end
        return AW'(ix - XW'(1));
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx,
                                               input logic [XW-1:0] cap);
        logic [XW-1:0] ix;
        ix = XW'(idx) + XW'(1);
        if (ix >= cap) begin
            return '0;
        end
        return AW'(ix);
    endfunction

    logic          r_state, n_state;
    logic [CW-1:0] r_cap;
    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_rear, n_rear;
    logic [CW-1:0] r_fill, n_fill;

    logic          r_out_valid;
    logic [DW-1:0] r_out_data, n_out_data;
    logic [cdq_pkg::ST_W-1:0] r_out_status, n_out_status;
    logic          r_out_empty, n_out_empty;
    logic          r_out_full, n_out_full;
    logic [CW-1:0] r_out_occ;

    logic [XW-1:0] cap_eff;
    logic          dq_empty, dq_full;
    logic          in_fire, cfg_fire, out_fire;
    logic          is_push, is_read, is_pop, at_front;
    logic [cdq_pkg::REQ_W-1:0] req;

    cdq_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] rd_data;

    // Capacity clamped to 1..DEPTH
    always_comb begin
        cap_eff = XW'(r_cap);
        if (cap_eff == '0) begin
            cap_eff = XW'(1);
        end else if (cap_eff > XW'(DEPTH)) begin
            cap_eff = XW'(DEPTH);
        end
    end

    assign dq_empty = (r_fill == '0);
    assign dq_full  = (XW'(r_fill) >= cap_eff);

    assign out_fire        = r_out_valid && i_m_axis_tready;
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid
                             && (!r_out_valid || i_m_axis_tready);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_fire        = i_cfg_valid && o_cfg_ready;

    assign req      = i_s_axis_tuser;
    assign is_push  = (req == cdq_pkg::REQ_PUSH_FRONT) || (req == cdq_pkg::REQ_PUSH_REAR);
    assign is_pop   = (req == cdq_pkg::REQ_POP_FRONT) || (req == cdq_pkg::REQ_POP_REAR);
    assign is_read  = is_pop || (req == cdq_pkg::REQ_PEEK_FRONT)
                      || (req == cdq_pkg::REQ_PEEK_REAR);
    assign at_front = (req == cdq_pkg::REQ_POP_FRONT) || (req == cdq_pkg::REQ_PEEK_FRONT);

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_rear        = r_rear;
        n_fill        = r_fill;
        n_out_data    = '0;
        n_out_status  = cdq_pkg::ST_OK;
        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        wr_addr       = r_rear;
        rd_addr       = at_front ? r_front : r_rear;

        case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    n_front = '0;
                    n_rear  = '0;
                    n_fill  = '0;
                end else if (in_fire) begin
                    if (is_push) begin
                        if (dq_full) begin
                            n_out_status = cdq_pkg::ST_OVER;
                        end else begin
                            if (dq_empty) begin
                                n_front = '0;
                                n_rear  = '0;
                            end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
                                n_front = wrap_dec(r_front, cap_eff);
                            end else begin
                                n_rear = wrap_inc(r_rear, cap_eff);
                            end
                            wr_addr = (req == cdq_pkg::REQ_PUSH_FRONT) ? n_front : n_rear;
                            mem_ctl.wr_en = 1'b1;
                            n_fill = r_fill + CW'(1);
                        end
                    end else if (is_read) begin
                        if (dq_empty) begin
                            n_out_status = cdq_pkg::ST_UNDER;
                            n_out_data   = '1;
                        end else begin
                            mem_ctl.rd_en = 1'b1;
                            n_state       = S_READ;
                            if (is_pop) begin
                                if (r_fill == CW'(1)) begin
                                    n_front = '0;
                                    n_rear  = '0;
                                end else if (at_front) begin
                                    n_front = wrap_inc(r_front, cap_eff);
                                end else begin
                                    n_rear = wrap_dec(r_rear, cap_eff);
                                end
                                n_fill = r_fill - CW'(1);
                            end
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_empty = (n_fill == '0);
    assign n_out_full  = (XW'(n_fill) >= cap_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= cdq_pkg::CAP_RESET;
            r_front     <= '0;
            r_rear      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_rear  <= n_rear;
            r_fill  <= n_fill;
            if (cfg_fire) begin
                r_cap <= i_cfg_data;
            end
            // Reads finish in S_READ, when the store data is back
            if (r_state == S_READ) begin
                r_out_valid <= 1'b1;
            end else if (in_fire) begin
                r_out_valid <= !mem_ctl.rd_en;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
            r_out_empty  <= n_out_empty;
            r_out_full   <= n_out_full;
            r_out_occ    <= n_fill;
        end else if (r_state == S_READ) begin
            r_out_data <= rd_data;
        end
    end

    cdq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_axis_tdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PADW{1'b0}}, r_out_occ, r_out_full, r_out_empty, r_out_data};
    assign o_m_axis_tuser  = r_out_status;

endmodule

### verif/tb_circular_deque_core.sv
// Self-checking testbench of circular_deque_core: directed and random deque traffic.
`timescale 1ns / 1ps

module tb_circular_deque_core;
    import cdq_pkg::*;

    localparam int DEPTH           = 16;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 106;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 2000;

    // request codes the block leaves unused
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [ST_W-1:0]   status;
        logic              empty;
        logic              full;
        logic [CAP_W-1:0]  occupancy;
    } deque_result_t;

    class deque_scoreboard;
        deque_result_t     pending_results[$];
        logic [DATA_W-1:0] ring [DEPTH];
        int unsigned       front_idx;
        int unsigned       rear_idx;
        int unsigned       fill;
        logic [CAP_W-1:0]  cap_reg;
        int                failures;

        function new();
            front_idx = 0;
            rear_idx  = 0;
            fill      = 0;
            cap_reg   = CAP_RESET;
            failures  = 0;
        endfunction

        function int unsigned usable_capacity();
            if (cap_reg == 0) return 1;
            if (cap_reg > DEPTH) return DEPTH;
            return cap_reg;
        endfunction

        function int unsigned step_up(int unsigned idx, int unsigned cap);
            return (idx + 1 >= cap) ? 0 : idx + 1;
        endfunction

        function int unsigned step_down(int unsigned idx, int unsigned cap);
            return (idx == 0 || idx >= cap) ? cap - 1 : idx - 1;
        endfunction

        // a capacity write also drops every stored entry
        function void set_capacity(logic [CAP_W-1:0] cap);
            cap_reg   = cap;
            front_idx = 0;
            rear_idx  = 0;
            fill      = 0;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] word);
            deque_result_t res;
            int unsigned   cap;
            bit            from_front;
            cap = usable_capacity();
            res = '0;
            case (req)
                REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                    if (fill >= cap) begin
                        res.status = ST_OVER;
                    end else begin
                        if (fill == 0) begin
                            front_idx = 0;
                            rear_idx  = 0;
                        end else if (req == REQ_PUSH_FRONT) begin
                            front_idx = step_down(front_idx, cap);
                        end else begin
                            rear_idx = step_up(rear_idx, cap);
                        end
                        ring[(req == REQ_PUSH_FRONT) ? front_idx : rear_idx] = word;
                        fill++;
                    end
                end
                REQ_POP_FRONT, REQ_POP_REAR, REQ_PEEK_FRONT, REQ_PEEK_REAR: begin
                    if (fill == 0) begin
                        res.status = ST_UNDER;
                        res.data   = '1;
                    end else begin
                        from_front = (req == REQ_POP_FRONT || req == REQ_PEEK_FRONT);
                        res.data   = ring[from_front ? front_idx : rear_idx];
                        if (req == REQ_POP_FRONT || req == REQ_POP_REAR) begin
                            if (fill == 1) begin
                                front_idx = 0;
                                rear_idx  = 0;
                            end else if (from_front) begin
                                front_idx = step_up(front_idx, cap);
                            end else begin
                                rear_idx = step_down(rear_idx, cap);
                            end
                            fill--;
                        end
                    end
                end
                default: ;
            endcase
            res.status    = (res.status == ST_OK) ? ST_OK : res.status;
            res.empty     = (fill == 0);
            res.full      = (fill >= cap);
            res.occupancy = CAP_W'(fill);
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] tdata, logic [ST_W-1:0] tuser);
            deque_result_t exp;
            if (pending_results.size() == 0) begin
                $error("unexpected result: tdata=%h tuser=%h", tdata, tuser);
                failures++;
                return;
            end
            exp = pending_results.pop_front();
            if (tdata[DATA_W-1:0] !== exp.data) begin
                $error("result_data: expected %0d, actual %0d",
                       $signed(exp.data), $signed(tdata[DATA_W-1:0]));
                failures++;
            end
            if (tuser !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, tuser);
                failures++;
            end
            if (tdata[DATA_W] !== exp.empty) begin
                $error("is_empty: expected %0d, actual %0d", exp.empty, tdata[DATA_W]);
                failures++;
            end
            if (tdata[DATA_W+1] !== exp.full) begin
                $error("is_full: expected %0d, actual %0d", exp.full, tdata[DATA_W+1]);
                failures++;
            end
            if (tdata[DATA_W+2 +: CAP_W] !== exp.occupancy) begin
                $error("occupancy: expected %0d, actual %0d",
                       exp.occupancy, tdata[DATA_W+2 +: CAP_W]);
                failures++;
            end
            if (tdata[OUT_DATA_W-1:OUT_BITS] !== '0) begin
                $error("pad: expected 0, actual %h", tdata[OUT_DATA_W-1:OUT_BITS]);
                failures++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CAP_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic [REQ_W-1:0]      s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [ST_W-1:0]       o_m_axis_tuser;

    bit tx_idle   = 1'b0;
    bit rx_idle   = 1'b0;
    bit hold_off  = 1'b0;

    deque_scoreboard sb;

    circular_deque_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // called right after a rising edge; leaves tvalid high for back-to-back traffic
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] word);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(req, word);
    endtask

    // capacity is only written with the deque idle and nothing outstanding
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_capacity(cap);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // push_pct steers the fill level so full and empty are both visited often
    function automatic logic [REQ_W-1:0] pick_req(int unsigned push_pct);
        int unsigned r;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
        r = $urandom_range(0, 99);
        if (r < 4)  return $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
        if (r < 34) return REQ_POP_FRONT;
        if (r < 64) return REQ_POP_REAR;
        if (r < 82) return REQ_PEEK_FRONT;
        return REQ_PEEK_REAR;
    endfunction

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (rx_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready) ||
                (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_circular_deque_core failed");
        $finish;
    end

    initial begin
        logic [CAP_W-1:0] cap_plan [NUM_PHASES];
        int unsigned      push_pct;
        cap_plan = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd2, 5'd3, 5'd4, 5'd7, 5'd9, 5'd15, 5'd24,
                     5'd16};
        sb = new();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty deque at reset capacity: reads underflow, then pushes, peeks and pops
        send_req(REQ_POP_FRONT, 32'h1234_5678);
        send_req(REQ_POP_REAR, '0);
        send_req(REQ_PEEK_FRONT, '1);
        send_req(REQ_PEEK_REAR, '0);
        send_req(REQ_SPARE_LO, '1);
        send_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_req(REQ_PUSH_REAR, 32'h8000_0000);
        send_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_req(REQ_PUSH_REAR, 32'h0000_0000);
        send_req(REQ_SPARE_HI, 32'hA5A5_5A5A);
        send_req(REQ_PEEK_FRONT, '0);
        send_req(REQ_PEEK_REAR, '0);
        send_req(REQ_POP_REAR, '0);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_POP_FRONT, '0);
        // last entry leaves, indices snap back to zero
        send_req(REQ_POP_REAR, '0);
        send_req(REQ_POP_FRONT, '0);

        // two-entry ring: wrap both ways and overflow
        write_capacity(5'd2);
        send_req(REQ_PUSH_REAR, 32'h0000_0001);
        send_req(REQ_PUSH_FRONT, 32'h0000_0002);
        send_req(REQ_PUSH_REAR, 32'h0000_0003);
        send_req(REQ_PUSH_FRONT, 32'h0000_0004);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_PUSH_REAR, 32'hDEAD_BEEF);
        send_req(REQ_POP_REAR, '0);
        send_req(REQ_POP_REAR, '0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_capacity(cap_plan[phase]);
            tx_idle = (phase % 4 != 3) && (phase != NUM_PHASES - 1);
            rx_idle = (phase % 3 != 1) && (phase != NUM_PHASES - 1);
            if (phase == 2) hold_off = 1'b1;
            push_pct = 50;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 16 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 80;
                        1:       push_pct = 50;
                        default: push_pct = 20;
                    endcase
                end
                send_req(pick_req(push_pct), pick_word());
                if (tx_idle && $urandom_range(0, 5) == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge i_clk);
                end
            end
            s_tvalid <= 1'b0;
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_circular_deque_core passed");
        else
            $display("tb_circular_deque_core failed");
        $finish;
    end

endmodule
